// ===== hdl/serial_frame_deframer_macros.svh =====
// Assertion macros for the deframer modules; only the parser uses them.
`ifndef SERIAL_FRAME_DEFRAMER_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sfd_pkg.sv =====
// Types and constants shared by the serial frame deframer modules.
package sfd_pkg;

  localparam int unsigned NUM_SYNC    = 4;
  localparam int unsigned COUNT_BYTES = 2;
  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned CFG_IDX_W   = $clog2(NUM_SYNC);

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FOURTH = 2'd3;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_SYNC2   = 3'd2,
    PH_SYNC3   = 3'd3,
    PH_PURPOSE = 3'd4,
    PH_OPCODE  = 3'd5,
    PH_COUNT   = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_DELIVERED = 2'd1,
    EV_DROPPED   = 2'd2
  } event_t;

  typedef logic [NUM_SYNC-1:0][7:0] sync_bytes_t;

  typedef struct packed {
    logic        word_valid;
    logic [31:0] payload_word;
    logic [15:0] word_index;
    event_t      frame_event;
    logic [7:0]  frame_purpose;
    logic [7:0]  frame_opcode;
    logic [15:0] frame_words;
  } result_t;

endpackage

// ===== hdl/sfd_parser.sv =====
// Frame parser: phase machine, byte assembly and per-item result.
`include "serial_frame_deframer_macros.svh"

module sfd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                mode,
  input  logic [7:0]          rx_byte,
  input  sfd_pkg::sync_bytes_t sync,
  output sfd_pkg::result_t    res
);
  import sfd_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  byte_cnt, byte_cnt_next;
  logic [23:0] shift, shift_next;
  logic [7:0]  purpose, purpose_next;
  logic [7:0]  opcode, opcode_next;
  logic [15:0] declared, declared_next;
  logic [15:0] received, received_next;
  logic        busy, busy_next;

  logic        sync_hit;
  logic        count_done;
  logic        word_done;
  logic [15:0] count_value;
  logic [15:0] received_inc;
  logic        finish;

  assign sync_hit     = (rx_byte == sync[phase[1:0]]);
  assign count_value  = {rx_byte, shift[23:16]};
  assign count_done   = (byte_cnt == 2'(COUNT_BYTES - 1));
  assign word_done    = (byte_cnt == 2'(WORD_BYTES - 1));
  assign received_inc = received + 16'd1;
  assign finish = (mode == MODE_BYTE) &&
                  (((phase == PH_COUNT) && count_done && (count_value == 16'd0)) ||
                   ((phase == PH_PAYLOAD) && word_done && (received_inc == declared)));

  // Next phase
  always_comb begin
    phase_next = phase;
    if (mode == MODE_BYTE) begin
      unique case (phase)
        PH_HUNT, PH_SYNC1, PH_SYNC2: phase_next = sync_hit ? phase_t'(phase + 3'd1) : PH_HUNT;
        PH_SYNC3:   phase_next = sync_hit ? PH_PURPOSE : PH_HUNT;
        PH_PURPOSE: phase_next = PH_OPCODE;
        PH_OPCODE:  phase_next = PH_COUNT;
        PH_COUNT: begin
          if (count_done) phase_next = finish ? PH_HUNT : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (finish) phase_next = PH_HUNT;
        end
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    byte_cnt_next = byte_cnt;
    shift_next    = shift;
    purpose_next  = purpose;
    opcode_next   = opcode;
    declared_next = declared;
    received_next = received;
    busy_next     = busy;
    res.word_valid   = 1'b0;
    res.payload_word = 32'd0;
    res.word_index   = 16'd0;
    res.frame_event  = EV_NONE;
    if (mode == MODE_RELEASE) begin
      busy_next = 1'b0;
    end else begin
      unique case (phase)
        PH_SYNC3: begin
          if (sync_hit) begin
            declared_next = 16'd0;
            received_next = 16'd0;
          end
        end
        PH_PURPOSE: purpose_next = rx_byte;
        PH_OPCODE: begin
          opcode_next   = rx_byte;
          byte_cnt_next = 2'd0;
        end
        PH_COUNT: begin
          shift_next    = {rx_byte, shift[23:8]};
          byte_cnt_next = byte_cnt + 2'd1;
          if (count_done) begin
            declared_next = count_value;
            received_next = 16'd0;
            byte_cnt_next = 2'd0;
          end
        end
        PH_PAYLOAD: begin
          shift_next    = {rx_byte, shift[23:8]};
          byte_cnt_next = byte_cnt + 2'd1;
          if (word_done) begin
            res.word_valid   = 1'b1;
            res.payload_word = {rx_byte, shift};
            res.word_index   = received;
            received_next    = received_inc;
          end
        end
        default: begin
        end
      endcase
      if (finish) begin
        res.frame_event = busy ? EV_DROPPED : EV_DELIVERED;
        busy_next       = 1'b1;
      end
    end
    res.frame_purpose = purpose_next;
    res.frame_opcode  = opcode_next;
    res.frame_words   = declared_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      byte_cnt <= 2'd0;
      purpose  <= 8'd0;
      opcode   <= 8'd0;
      declared <= 16'd0;
      received <= 16'd0;
      busy     <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      byte_cnt <= byte_cnt_next;
      purpose  <= purpose_next;
      opcode   <= opcode_next;
      declared <= declared_next;
      received <= received_next;
      busy     <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift <= shift_next;
    end
  end

  `SFD_ASSERT_NEXT(a_event_to_hunt, clk, rst, step && (res.frame_event != EV_NONE), phase == PH_HUNT, "frame end did not return to hunting")
  `SFD_ASSERT_NEXT(a_deliver_sets_busy, clk, rst, step && (res.frame_event == EV_DELIVERED), busy, "delivered frame did not mark consumer busy")
  `SFD_ASSERT_NOW(a_word_in_payload, clk, rst, step && res.word_valid, (phase == PH_PAYLOAD) && word_done, "word emitted outside payload")
  `SFD_ASSERT_NEXT(a_release_clears, clk, rst, step && (mode == MODE_RELEASE), !busy, "release did not clear busy")

endmodule

// ===== hdl/sfd_out_reg.sv =====
// Result register between the parser and the output channel.
module sfd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfd_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             in_ready,
  output sfd_pkg::result_t res_q
);
  import sfd_pkg::*;

  logic out_valid_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

// ===== hdl/serial_frame_deframer.sv =====
// Serial frame deframer top level: sync registers, parser and result register.
// Input channel (in_valid/in_ready) carries one item per handshake: mode 0 is a
// received byte in rx_byte, mode 1 is the consumer releasing its frame.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// a completed payload word with its index, a frame event (delivered/dropped)
// and the held purpose, opcode and word count of the current frame.
// The four sync bytes are written through cfg_wen/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// The result of an item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle while the receiver takes each result; the parser
// state update is a single short combinational step into the result register.
// When the receiver stalls, the result register holds and in_ready falls
// until the result is taken; an item is still taken in the cycle the
// waiting result leaves.
// Reset (rst, synchronous): parser hunts for the first sync byte, held frame
// fields and sync bytes clear to zero, consumer is not busy, output empty.
module serial_frame_deframer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             word_valid,
  output logic [31:0]                      payload_word,
  output logic [15:0]                      word_index,
  output logic [1:0]                       frame_event,
  output logic [7:0]                       frame_purpose,
  output logic [7:0]                       frame_opcode,
  output logic [15:0]                      frame_words
);
  import sfd_pkg::*;

  sync_bytes_t sync;
  result_t     res;
  result_t     res_q;
  logic        step;

  assign step = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync[0] <= cfg_data;
        CFG_SYNC_SECOND: sync[1] <= cfg_data;
        CFG_SYNC_THIRD:  sync[2] <= cfg_data;
        CFG_SYNC_FOURTH: sync[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .mode    (mode),
    .rx_byte (rx_byte),
    .sync    (sync),
    .res     (res)
  );

  sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .in_ready  (in_ready),
    .res_q     (res_q)
  );

  assign word_valid    = res_q.word_valid;
  assign payload_word  = res_q.payload_word;
  assign word_index    = res_q.word_index;
  assign frame_event   = res_q.frame_event;
  assign frame_purpose = res_q.frame_purpose;
  assign frame_opcode  = res_q.frame_opcode;
  assign frame_words   = res_q.frame_words;

endmodule

// ===== tb/serial_frame_deframer_tb.sv =====
// Testbench for the serial frame deframer: frame, release and sync traffic checked per item.
`timescale 1ns / 1ps

module serial_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned PHASE_COUNT  = 5;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 mode = MODE_BYTE;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 word_valid;
  logic [31:0]          payload_word;
  logic [15:0]          word_index;
  logic [1:0]           frame_event;
  logic [7:0]           frame_purpose;
  logic [7:0]           frame_opcode;
  logic [15:0]          frame_words;

  serial_frame_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .word_valid    (word_valid),
    .payload_word  (payload_word),
    .word_index    (word_index),
    .frame_event   (frame_event),
    .frame_purpose (frame_purpose),
    .frame_opcode  (frame_opcode),
    .frame_words   (frame_words)
  );

  logic [7:0]  pred_sync [NUM_SYNC];
  phase_t      pred_phase;
  logic [1:0]  pred_pos;
  logic [31:0] pred_shift;
  logic [7:0]  pred_purpose;
  logic [7:0]  pred_opcode;
  logic [15:0] pred_declared;
  logic [15:0] pred_received;
  logic        pred_busy;

  result_t     pending_results [$];
  logic [7:0]  cur_sync [NUM_SYNC] = '{default: 8'h00};
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  bit          tx_steady = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic event_t close_frame();
    pred_phase = PH_HUNT;
    if (pred_busy) return EV_DROPPED;
    pred_busy = 1'b1;
    return EV_DELIVERED;
  endfunction

  function automatic result_t deframe_step(input logic m, input logic [7:0] b);
    result_t r;
    r = '0;
    r.frame_event = EV_NONE;
    if (m == MODE_RELEASE) begin
      pred_busy = 1'b0;
    end else begin
      case (pred_phase)
        PH_HUNT, PH_SYNC1, PH_SYNC2: begin
          if (b == pred_sync[pred_phase[1:0]]) pred_phase = phase_t'(pred_phase + 3'd1);
          else pred_phase = PH_HUNT;
        end
        PH_SYNC3: begin
          if (b == pred_sync[CFG_SYNC_FOURTH]) begin
            pred_phase = PH_PURPOSE;
            pred_declared = '0;
            pred_received = '0;
          end else begin
            pred_phase = PH_HUNT;
          end
        end
        PH_PURPOSE: begin
          pred_purpose = b;
          pred_phase = PH_OPCODE;
        end
        PH_OPCODE: begin
          pred_opcode = b;
          pred_shift = '0;
          pred_pos = '0;
          pred_phase = PH_COUNT;
        end
        PH_COUNT: begin
          pred_shift = (pred_shift >> 8) | (32'(b) << 8);
          pred_pos = pred_pos + 2'd1;
          if (pred_pos == 2'(COUNT_BYTES)) begin
            pred_declared = pred_shift[15:0];
            pred_received = '0;
            pred_pos = '0;
            if (pred_declared == 16'd0) r.frame_event = close_frame();
            else pred_phase = PH_PAYLOAD;
          end
        end
        default: begin
          pred_shift = (pred_shift >> 8) | (32'(b) << 24);
          pred_pos = pred_pos + 2'd1;
          if (pred_pos == 2'd0) begin
            r.word_valid = 1'b1;
            r.payload_word = pred_shift;
            r.word_index = pred_received;
            pred_received = pred_received + 16'd1;
            if (pred_received == pred_declared) r.frame_event = close_frame();
          end
        end
      endcase
    end
    r.frame_purpose = pred_purpose;
    r.frame_opcode = pred_opcode;
    r.frame_words = pred_declared;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (pred_sync[i]) pred_sync[i] = 8'h00;
      pred_phase = PH_HUNT;
      pred_pos = '0;
      pred_shift = '0;
      pred_purpose = '0;
      pred_opcode = '0;
      pred_declared = '0;
      pred_received = '0;
      pred_busy = 1'b0;
    end else begin
      if (cfg_wen) pred_sync[cfg_index] = cfg_data;
      if (in_valid && in_ready) pending_results.push_back(deframe_step(mode, rx_byte));
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) report_mismatch($sformatf("%s expected %h got %h", name, want, got));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = pending_results.pop_front();
        check_field("word_valid", want.word_valid, word_valid);
        check_field("payload_word", want.payload_word, payload_word);
        check_field("word_index", want.word_index, word_index);
        check_field("frame_event", want.frame_event, frame_event);
        check_field("frame_purpose", want.frame_purpose, frame_purpose);
        check_field("frame_opcode", want.frame_opcode, frame_opcode);
        check_field("frame_words", want.frame_words, frame_words);
      end
    end
  end

  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_sink
    int unsigned run_len;
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(4) == 0) run_len = $urandom_range(50, 200);
      else run_len = $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = idle_len();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input logic m, input logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_release();
    send_item(MODE_RELEASE, 8'($urandom));
  endtask

  task automatic send_header(input logic [7:0] purpose, input logic [7:0] opcode,
                             input logic [15:0] count);
    foreach (cur_sync[i]) send_item(MODE_BYTE, cur_sync[i]);
    send_item(MODE_BYTE, purpose);
    send_item(MODE_BYTE, opcode);
    send_item(MODE_BYTE, count[7:0]);
    send_item(MODE_BYTE, count[15:8]);
  endtask

  task automatic send_word(input logic [31:0] w);
    send_item(MODE_BYTE, w[7:0]);
    send_item(MODE_BYTE, w[15:8]);
    send_item(MODE_BYTE, w[23:16]);
    send_item(MODE_BYTE, w[31:24]);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned count;
    int          rel_at;
    logic [31:0] w;
    pick = $urandom_range(99);
    if (pick < 70) count = $urandom_range(3);
    else if (pick < 95) count = $urandom_range(4, 8);
    else count = $urandom_range(9, 24);
    rel_at = -1;
    if (count != 0 && $urandom_range(7) == 0) rel_at = $urandom_range(count - 1);
    send_header(8'($urandom), 8'($urandom), 16'(count));
    for (int i = 0; i < count; i++) begin
      if (i == rel_at) send_release();
      pick = $urandom_range(9);
      if (pick == 0) w = 32'h0000_0000;
      else if (pick == 1) w = 32'hFFFF_FFFF;
      else w = $urandom;
      send_word(w);
    end
  endtask

  task automatic send_broken_sync();
    int unsigned depth;
    depth = $urandom_range(1, 3);
    for (int i = 0; i < depth; i++) send_item(MODE_BYTE, cur_sync[i]);
    send_item(MODE_BYTE, cur_sync[depth] ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == cur_sync[0]) b = ~b;
    send_item(MODE_BYTE, b);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    cur_sync[idx] = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_sync_pattern(input logic [7:0] s0, input logic [7:0] s1,
                                  input logic [7:0] s2, input logic [7:0] s3);
    wait_for_drain();
    write_reg(CFG_SYNC_FIRST, s0);
    write_reg(CFG_SYNC_SECOND, s1);
    write_reg(CFG_SYNC_THIRD, s2);
    write_reg(CFG_SYNC_FOURTH, s3);
  endtask

  task automatic test_reset_sync_defaults();
    send_header(8'h12, 8'h34, 16'd0);
  endtask

  task automatic test_directed_cases();
    set_sync_pattern(8'hA5, 8'h5A, 8'hC3, 8'h3C);
    // repeated first-sync value sends the parser back to hunting, not to a new match
    send_item(MODE_BYTE, 8'hA5);
    send_item(MODE_BYTE, 8'hA5);
    // release mid-word clears busy without disturbing the parse
    send_header(8'h00, 8'hFF, 16'd1);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'hFF);
    send_release();
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'hFF);
    // zero-count frame while busy: dropped
    send_header(8'hFF, 8'h00, 16'd0);
    send_release();
    send_release();
  endtask

  task automatic run_frames(input int unsigned frames);
    repeat (frames) begin
      if ($urandom_range(1) == 0) send_release();
      send_random_frame();
    end
  endtask

  task automatic test_sync_extremes();
    set_sync_pattern(8'h00, 8'h00, 8'h00, 8'h00);
    run_frames(4);
    set_sync_pattern(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_frames(4);
    set_sync_pattern(8'h00, 8'hFF, 8'h00, 8'hFF);
    run_frames(4);
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    int unsigned pick;
    bit          paused;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_sync_pattern(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      goal = items_sent + RANDOM_ITEMS / PHASE_COUNT;
      paused = 1'b0;
      while (items_sent < goal) begin
        tx_steady = ($urandom_range(3) == 0);
        // hold off until every result is back
        if (!paused && items_sent + 130 >= goal) begin
          wait_for_drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 60) send_random_frame();
        else if (pick < 72) send_release();
        else if (pick < 88) send_broken_sync();
        else send_noise();
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_sync_defaults();
    test_directed_cases();
    test_sync_extremes();
    test_random_frames();
    wait_for_drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
